[hdl/hrsp_pkg.sv]
// Shared types, codes and constants of the hex record stream parser.
package hrsp_pkg;

    localparam int MEMORY_BYTES = 16384;
    localparam int LIMIT_W = 15;
    localparam logic [LIMIT_W-1:0] BYTE_LIMIT_RESET = 15'd16384;

    localparam logic [1:0] ACT_CHAR    = 2'd0;
    localparam logic [1:0] ACT_END     = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_FAIL  = 2'd2;

    localparam logic [1:0] ERR_COLON = 2'd0;
    localparam logic [1:0] ERR_DIGIT = 2'd1;
    localparam logic [1:0] ERR_END   = 2'd2;
    localparam logic [1:0] ERR_SUM   = 2'd3;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] ALPHA_BIAS = 8'h37;

    typedef enum logic [2:0] {
        PH_START,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_UPPER,
        PH_CHECK,
        PH_DISCARD
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] write_address;
        logic [7:0]  write_value;
        logic [1:0]  error_code;
    } result_t;

endpackage

[hdl/hrsp_parser.sv]
// Parser state and the per-character record decoding step.
module hrsp_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  logic [1:0]                   action,
    input  logic [7:0]                   char_in,
    input  logic [hrsp_pkg::LIMIT_W-1:0] byte_limit,
    output logic                         res_valid,
    output hrsp_pkg::result_t            res
);

    localparam logic [16:0] MEM_LIMIT = 17'(hrsp_pkg::MEMORY_BYTES);

    hrsp_pkg::phase_t phase_reg, phase_next;
    logic        hnp_reg, hnp_next;
    logic [3:0]  hold_reg, hold_next;
    logic        fbi_reg, fbi_next;
    logic [7:0]  rem_reg, rem_next;
    logic [15:0] addr_reg, addr_next;
    logic        type1_reg, type1_next;
    logic        upper_nz_reg, upper_nz_next;
    logic [7:0]  sum_reg, sum_next;
    logic        stopped_reg, stopped_next;

    logic [16:0] limit;
    logic        digit_ok;
    logic [3:0]  digit;
    logic [7:0]  byte_val;

    always_comb begin
        limit = ({2'b00, byte_limit} > MEM_LIMIT) ? MEM_LIMIT : {2'b00, byte_limit};
        digit_ok = 1'b1;
        digit = 4'd0;
        if (char_in >= hrsp_pkg::CHAR_ZERO && char_in <= hrsp_pkg::CHAR_NINE) begin
            digit = char_in[3:0];
        end else if (char_in >= hrsp_pkg::CHAR_UA && char_in <= hrsp_pkg::CHAR_UF) begin
            digit = 4'(char_in - hrsp_pkg::ALPHA_BIAS);
        end else begin
            digit_ok = 1'b0;
        end
        byte_val = {hold_reg, digit};
    end

    always_comb begin
        phase_next = phase_reg;
        hnp_next = hnp_reg;
        hold_next = hold_reg;
        fbi_next = fbi_reg;
        rem_next = rem_reg;
        addr_next = addr_reg;
        type1_next = type1_reg;
        upper_nz_next = upper_nz_reg;
        sum_next = sum_reg;
        stopped_next = stopped_reg;
        res_valid = 1'b0;
        res = '0;

        if (step_en) begin
            if (action == hrsp_pkg::ACT_RESTART) begin
                phase_next = hrsp_pkg::PH_START;
                hnp_next = 1'b0;
                hold_next = 4'd0;
                fbi_next = 1'b0;
                rem_next = 8'd0;
                addr_next = 16'd0;
                type1_next = 1'b0;
                upper_nz_next = 1'b0;
                sum_next = 8'd0;
                stopped_next = 1'b0;
            end else if (!stopped_reg && action == hrsp_pkg::ACT_END) begin
                res_valid = 1'b1;
                res.kind = hrsp_pkg::KIND_FAIL;
                if (phase_reg == hrsp_pkg::PH_START) begin
                    res.error_code = hrsp_pkg::ERR_COLON;
                end else if (phase_reg == hrsp_pkg::PH_DISCARD) begin
                    // No further record can follow, so a good non-final record still fails.
                    if (sum_reg != 8'd0) begin
                        res.error_code = hrsp_pkg::ERR_SUM;
                    end else if (type1_reg) begin
                        res.kind = hrsp_pkg::KIND_OK;
                    end else begin
                        phase_next = hrsp_pkg::PH_START;
                        res.error_code = hrsp_pkg::ERR_COLON;
                    end
                end else begin
                    res.error_code = hrsp_pkg::ERR_END;
                end
            end else if (!stopped_reg && action == hrsp_pkg::ACT_CHAR) begin
                if (phase_reg == hrsp_pkg::PH_START) begin
                    if (char_in == hrsp_pkg::CHAR_LF || char_in == hrsp_pkg::CHAR_CR) begin
                        res_valid = 1'b0;
                    end else if (char_in == hrsp_pkg::CHAR_SEMI) begin
                        res_valid = 1'b1;
                        res.kind = hrsp_pkg::KIND_OK;
                    end else if (char_in != hrsp_pkg::CHAR_COLON) begin
                        res_valid = 1'b1;
                        res.kind = hrsp_pkg::KIND_FAIL;
                        res.error_code = hrsp_pkg::ERR_COLON;
                    end else begin
                        sum_next = 8'd0;
                        hnp_next = 1'b0;
                        fbi_next = 1'b0;
                        phase_next = hrsp_pkg::PH_COUNT;
                    end
                end else if (phase_reg == hrsp_pkg::PH_DISCARD) begin
                    if (sum_reg != 8'd0) begin
                        res_valid = 1'b1;
                        res.kind = hrsp_pkg::KIND_FAIL;
                        res.error_code = hrsp_pkg::ERR_SUM;
                    end else if (type1_reg) begin
                        res_valid = 1'b1;
                        res.kind = hrsp_pkg::KIND_OK;
                    end else begin
                        phase_next = hrsp_pkg::PH_START;
                    end
                end else if (!digit_ok) begin
                    res_valid = 1'b1;
                    res.kind = hrsp_pkg::KIND_FAIL;
                    res.error_code = hrsp_pkg::ERR_DIGIT;
                end else if (!hnp_reg) begin
                    hold_next = digit;
                    hnp_next = 1'b1;
                end else begin
                    hnp_next = 1'b0;
                    sum_next = sum_reg + byte_val;
                    case (phase_reg)
                        hrsp_pkg::PH_COUNT: begin
                            rem_next = byte_val;
                            fbi_next = 1'b0;
                            phase_next = hrsp_pkg::PH_ADDR;
                        end
                        hrsp_pkg::PH_ADDR: begin
                            if (!fbi_reg) begin
                                addr_next = {8'd0, byte_val};
                                fbi_next = 1'b1;
                            end else begin
                                addr_next = {addr_reg[7:0], byte_val};
                                fbi_next = 1'b0;
                                phase_next = hrsp_pkg::PH_TYPE;
                            end
                        end
                        hrsp_pkg::PH_TYPE: begin
                            type1_next = (byte_val == 8'd1);
                            if (byte_val == 8'd0) begin
                                if (rem_reg == 8'd0) begin
                                    upper_nz_next = 1'b0;
                                    phase_next = hrsp_pkg::PH_CHECK;
                                end else begin
                                    phase_next = hrsp_pkg::PH_DATA;
                                end
                            end else if (byte_val == 8'd4) begin
                                fbi_next = 1'b0;
                                phase_next = hrsp_pkg::PH_UPPER;
                            end else begin
                                phase_next = hrsp_pkg::PH_CHECK;
                            end
                        end
                        hrsp_pkg::PH_DATA: begin
                            // Past the limit the address stops advancing.
                            if (!upper_nz_reg && {1'b0, addr_reg} < limit) begin
                                res_valid = 1'b1;
                                res.kind = hrsp_pkg::KIND_WRITE;
                                res.write_address = addr_reg[13:0];
                                res.write_value = byte_val;
                                addr_next = addr_reg + 16'd1;
                            end
                            rem_next = rem_reg - 8'd1;
                            if (rem_reg == 8'd1) begin
                                upper_nz_next = 1'b0;
                                phase_next = hrsp_pkg::PH_CHECK;
                            end
                        end
                        hrsp_pkg::PH_UPPER: begin
                            if (!fbi_reg) begin
                                upper_nz_next = (byte_val != 8'd0);
                                fbi_next = 1'b1;
                            end else begin
                                upper_nz_next = upper_nz_reg | (byte_val != 8'd0);
                                fbi_next = 1'b0;
                                phase_next = hrsp_pkg::PH_CHECK;
                            end
                        end
                        default: begin
                            phase_next = hrsp_pkg::PH_DISCARD;
                        end
                    endcase
                end
            end
            if (res_valid && res.kind != hrsp_pkg::KIND_WRITE) begin
                stopped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hrsp_pkg::PH_START;
            hnp_reg <= 1'b0;
            hold_reg <= 4'd0;
            fbi_reg <= 1'b0;
            rem_reg <= 8'd0;
            addr_reg <= 16'd0;
            type1_reg <= 1'b0;
            upper_nz_reg <= 1'b0;
            sum_reg <= 8'd0;
            stopped_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            hnp_reg <= hnp_next;
            hold_reg <= hold_next;
            fbi_reg <= fbi_next;
            rem_reg <= rem_next;
            addr_reg <= addr_next;
            type1_reg <= type1_next;
            upper_nz_reg <= upper_nz_next;
            sum_reg <= sum_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

[hdl/hex_record_stream_parser_core.sv]
// Hex record stream parser: top level with input, result and configuration registers.
//
// The s_ channel carries one request per character (action, char_in); action
// 0 is a character, 1 end of input, 2 restart. The m_ channel returns at most
// one result per request: a memory byte write, load finished ok or load
// failed with an error code. Requests that cause no result are absorbed.
// The cfg channel writes byte_limit; it is always ready and should only be
// used while the parser is idle.
// Each request is held in an input register and then decoded into the result
// register, from which its result is presented on the m_ channel. One request
// is taken every cycle while the result register can advance; the parser state
// updates once per request.
// When the receiver stalls, the result register holds its item and the input
// register still accepts one more request, after which s_ready drops until
// m_ready returns.
// Synchronous reset clears the parser, empties both registers and sets
// byte_limit to 16384.
module hex_record_stream_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [13:0] m_write_address,
    output logic [7:0]  m_write_value,
    output logic [1:0]  m_error_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data
);

    logic [hrsp_pkg::LIMIT_W-1:0] limit_reg;
    logic                         in_valid_reg;
    logic [1:0]                   action_reg;
    logic [7:0]                   char_reg;
    logic                         out_valid_reg;
    hrsp_pkg::result_t            out_reg;

    logic              advance;
    logic              step_res_valid;
    hrsp_pkg::result_t step_res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    hrsp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .action     (action_reg),
        .char_in    (char_reg),
        .byte_limit (limit_reg),
        .res_valid  (step_res_valid),
        .res        (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= hrsp_pkg::BYTE_LIMIT_RESET;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= step_res_valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            char_reg <= s_char_in;
        end
        if (advance && step_res_valid) begin
            out_reg <= step_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_kind = out_reg.kind;
    assign m_write_address = out_reg.write_address;
    assign m_write_value = out_reg.write_value;
    assign m_error_code = out_reg.error_code;

endmodule
